[design/lrc_pkg.sv]
// shared types and constants of the chunk position cache
package lrc_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned STAMP_W  = 32;

  typedef enum logic [1:0] {
    FUNC_TOUCH    = 2'd0,
    FUNC_MARK     = 2'd1,
    FUNC_FRAME    = 2'd2,
    FUNC_MARK_ALL = 2'd3
  } func_e;

  typedef struct packed {
    func_e              func;
    logic signed [15:0] grid_x;
    logic signed [15:0] grid_y;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [3:0]         slot;
    logic               evicted;
    logic signed [15:0] evicted_x;
    logic signed [15:0] evicted_y;
    logic               redraw;
    logic [4:0]         occupancy;
  } out_t;

  typedef struct packed {
    logic [15:0]        col;
    logic [15:0]        row;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ent_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic             data;
  } drt_wr_t;

endpackage

[design/lru_tile_chunk_cache_unit.sv]
// chunk position cache: least recently used, fully associative, 16 entries
//
// Input channel in_valid_i / in_stall_o / in_i carries one operation per beat:
// touch, mark dirty, end frame or mark all dirty. Output channel
// out_valid_o / out_stall_i / out_o returns exactly one result beat for each
// input beat, in order.
// Operations run one at a time. Entries sit in a synchronous memory read one
// per cycle, so a lookup scans the cached entries in slot order until it hits
// or has read them all; a miss on a full cache then needs two writes (victim
// move and append), and mark all dirty writes the dirty flag of each cached
// entry in turn.
// The output register decouples the two channels: a new operation may start
// while the previous result still waits for the receiver; a stalled result
// holds and the next one waits in the sequencer until the register frees.
// Reset empties the cache and zeroes the frame counter; memory contents are
// not cleared and are never read before being written.
module lru_tile_chunk_cache_unit import lrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_o
);

  logic             res_valid;
  logic             res_stall;
  out_t             res;
  logic [IDX_W-1:0] rd_addr;
  entry_t           ent_rdata;
  logic             drt_rdata;
  ent_wr_t          ent_wr;
  drt_wr_t          drt_wr;
  logic             out_valid_q;
  out_t             out_q;

  lrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_stall_i (res_stall),
    .rd_addr_o   (rd_addr),
    .ent_rdata_i (ent_rdata),
    .drt_rdata_i (drt_rdata),
    .ent_wr_o    (ent_wr),
    .drt_wr_o    (drt_wr)
  );

  lrc_ram #(
    .Width (ENTRY_W),
    .Depth (CAPACITY)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_wr.en),
    .waddr_i (ent_wr.addr),
    .wdata_i (ent_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (ent_rdata)
  );

  lrc_ram #(
    .Width (1),
    .Depth (CAPACITY)
  ) u_drt_ram (
    .clk_i   (clk_i),
    .we_i    (drt_wr.en),
    .waddr_i (drt_wr.addr),
    .wdata_i (drt_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (drt_rdata)
  );

  // result waits in the sequencer while the output register is held
  assign res_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

[design/lrc_ram.sv]
// simple dual port ram, one write and one registered read per cycle
module lrc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/lrc_ctrl.sv]
// sequencer: lookup scan, least recent search, read-modify-write of entries
module lrc_ctrl import lrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  in_t              in_i,
  output logic             in_stall_o,
  output logic             res_valid_o,
  output out_t             res_o,
  input  logic             res_stall_i,
  output logic [IDX_W-1:0] rd_addr_o,
  input  entry_t           ent_rdata_i,
  input  logic             drt_rdata_i,
  output ent_wr_t          ent_wr_o,
  output drt_wr_t          drt_wr_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_APPEND = 6'b001000,
    ST_SWEEP  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  func_e              func_q, func_d;
  logic [15:0]        x_q, x_d;
  logic [15:0]        y_q, y_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [STAMP_W-1:0] frame_q, frame_d;
  logic [CNT_W-1:0]   rd_cnt_q, rd_cnt_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pend_idx_q, pend_idx_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic               hit_dirty_q, hit_dirty_d;
  entry_t             min_ent_q, min_ent_d;
  logic [IDX_W-1:0]   min_idx_q, min_idx_d;
  entry_t             last_ent_q, last_ent_d;
  logic               last_dirty_q, last_dirty_d;
  out_t               res_q, res_d;
  logic [CNT_W-1:0]   last_idx;
  logic               match;
  entry_t             new_ent;

  assign last_idx = total_q - CNT_W'(1);
  assign match    = pend_q && (ent_rdata_i.col == x_q) && (ent_rdata_i.row == y_q);
  assign new_ent  = '{col: x_q, row: y_q, stamp: frame_q};

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    x_d          = x_q;
    y_d          = y_q;
    total_d      = total_q;
    frame_d      = frame_q;
    rd_cnt_d     = rd_cnt_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_dirty_d  = hit_dirty_q;
    min_ent_d    = min_ent_q;
    min_idx_d    = min_idx_q;
    last_ent_d   = last_ent_q;
    last_dirty_d = last_dirty_q;
    res_d        = res_q;
    ent_wr_o     = '0;
    drt_wr_o     = '0;
    rd_addr_o    = rd_cnt_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d   = in_i.func;
          x_d      = in_i.grid_x;
          y_d      = in_i.grid_y;
          res_d    = '0;
          rd_cnt_d = '0;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          case (in_i.func)
            FUNC_TOUCH, FUNC_MARK: begin
              state_d = (total_q == '0) ? ST_DECIDE : ST_SCAN;
            end
            FUNC_FRAME: begin
              frame_d = frame_q + STAMP_W'(1);
              state_d = ST_DONE;
            end
            FUNC_MARK_ALL: begin
              state_d = (total_q == '0) ? ST_DONE : ST_SWEEP;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the entry read the cycle before
        if (rd_cnt_q != total_q) begin
          rd_cnt_d   = rd_cnt_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = rd_cnt_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          // first lowest stamp wins ties
          if (pend_idx_q == '0 || ent_rdata_i.stamp < min_ent_q.stamp) begin
            min_ent_d = ent_rdata_i;
            min_idx_d = pend_idx_q;
          end
          last_ent_d   = ent_rdata_i;
          last_dirty_d = drt_rdata_i;
          if (match) begin
            found_d     = 1'b1;
            hit_idx_d   = pend_idx_q;
            hit_dirty_d = drt_rdata_i;
            state_d     = ST_DECIDE;
          end else if (CNT_W'(pend_idx_q) == last_idx) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (found_q) begin
          ent_wr_o     = '{en: 1'b1, addr: hit_idx_q, data: new_ent};
          drt_wr_o     = '{en: 1'b1, addr: hit_idx_q, data: (func_q == FUNC_MARK)};
          res_d.hit    = 1'b1;
          res_d.slot   = 4'(hit_idx_q);
          res_d.redraw = (func_q == FUNC_TOUCH) && hit_dirty_q;
          state_d      = ST_DONE;
        end else if (func_q == FUNC_MARK) begin
          state_d = ST_DONE;
        end else if (total_q != CNT_W'(CAPACITY)) begin
          ent_wr_o     = '{en: 1'b1, addr: total_q[IDX_W-1:0], data: new_ent};
          drt_wr_o     = '{en: 1'b1, addr: total_q[IDX_W-1:0], data: 1'b0};
          res_d.slot   = 4'(total_q);
          res_d.redraw = 1'b1;
          total_d      = total_q + CNT_W'(1);
          state_d      = ST_DONE;
        end else begin
          // full: last entry fills the victim slot, new entry goes last
          ent_wr_o        = '{en: 1'b1, addr: min_idx_q, data: last_ent_q};
          drt_wr_o        = '{en: 1'b1, addr: min_idx_q, data: last_dirty_q};
          res_d.evicted   = 1'b1;
          res_d.evicted_x = min_ent_q.col;
          res_d.evicted_y = min_ent_q.row;
          res_d.slot      = 4'(CAPACITY - 1);
          res_d.redraw    = 1'b1;
          state_d         = ST_APPEND;
        end
      end

      ST_APPEND: begin
        ent_wr_o = '{en: 1'b1, addr: IDX_W'(CAPACITY - 1), data: new_ent};
        drt_wr_o = '{en: 1'b1, addr: IDX_W'(CAPACITY - 1), data: 1'b0};
        state_d  = ST_DONE;
      end

      ST_SWEEP: begin
        drt_wr_o = '{en: 1'b1, addr: rd_cnt_q[IDX_W-1:0], data: 1'b1};
        rd_cnt_d = rd_cnt_q + CNT_W'(1);
        if (rd_cnt_q == last_idx) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!res_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= '0;
      frame_q <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      frame_q <= frame_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    x_q          <= x_d;
    y_q          <= y_d;
    rd_cnt_q     <= rd_cnt_d;
    pend_idx_q   <= pend_idx_d;
    hit_idx_q    <= hit_idx_d;
    hit_dirty_q  <= hit_dirty_d;
    min_ent_q    <= min_ent_d;
    min_idx_q    <= min_idx_d;
    last_ent_q   <= last_ent_d;
    last_dirty_q <= last_dirty_d;
    res_q        <= res_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  always_comb begin
    res_o           = res_q;
    res_o.occupancy = 5'(total_q);
  end

endmodule

[design/lrc_checker.sv]
// port level checks of the chunk position cache, bound to the top level
module lrc_checker import lrc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_o
);

  // held result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result beat changed");

  // one operation at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while an operation runs");

  // an eviction only happens on a miss into a full cache
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.evicted |->
      !out_o.hit && out_o.redraw && (out_o.occupancy == CAPACITY))
    else $error("eviction result inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.evicted |->
      (out_o.evicted_x == 16'sd0) && (out_o.evicted_y == 16'sd0))
    else $error("victim position shown without eviction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.occupancy <= CAPACITY)
    else $error("occupancy above capacity");

endmodule

bind lru_tile_chunk_cache_unit lrc_checker u_lrc_checker (.*);
